[hdl/ogp_pkg.sv]
// obstacle grid painter package: command and cell kind codes, config register indexes
// and the job and write-request structs shared by the walker and the top level
// no dependencies
package ogp_pkg;

	localparam int CMD_W = 3;
	localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DISC    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_HALF    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RECT    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_BCORNER = 3'd4;
	localparam logic [CMD_W-1:0] CMD_TCORNER = 3'd5;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd6;

	localparam int KIND_W = 3;
	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_FLUID  = 3'd0;
	localparam kind_t KIND_TOP    = 3'd1;
	localparam kind_t KIND_BOTTOM = 3'd2;
	localparam kind_t KIND_LEFT   = 3'd3;
	localparam kind_t KIND_RIGHT  = 3'd4;
	localparam kind_t KIND_OBST   = 3'd5;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

	// signed cell coordinates while walking a bounding box
	localparam int COORD_W = 10;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [7:0]       pos_x;
		logic [7:0]       pos_y;
		logic [6:0]       extent_a;
		logic [6:0]       extent_b;
	} ogp_job_t;

	typedef struct packed {
		logic               en;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} ogp_wr_t;

endpackage

[hdl/ogp_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module ogp_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/ogp_walker.sv]
// bounding box walker: steps one cell per cycle through a shape's box, keeps dx^2 and
// dy^2 by running sums and tests them against the shape threshold, clips, emits writes
// depends on ogp_pkg
module ogp_walker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  ogp_pkg::ogp_job_t job,
	input  logic [6:0]       rows_eff,
	input  logic [6:0]       cols_eff,
	output ogp_pkg::ogp_wr_t wr,
	output logic             done
);

	localparam logic [1:0] W_IDLE = 2'd0;
	localparam logic [1:0] W_SQ   = 2'd1;
	localparam logic [1:0] W_THR  = 2'd2;
	localparam logic [1:0] W_RUN  = 2'd3;

	localparam int CW = ogp_pkg::COORD_W;

	logic [1:0]    state_q;
	logic          disc_q;
	logic          rect_q;
	logic          ydn_q;
	logic [6:0]    r_q;
	logic [7:0]    nrows_q;
	logic [7:0]    ncols_q;
	logic [7:0]    j_q;
	logic [7:0]    k_q;
	logic [CW-1:0] xstart_q;
	logic [CW-1:0] x_q;
	logic [CW-1:0] y_q;
	logic [8:0]    dx_q;
	logic [8:0]    dy_q;
	logic [13:0]   sq_q;
	logic [13:0]   thr_q;
	logic [13:0]   dx2_q;
	logic [13:0]   dy2_q;

	logic          is_disc;
	logic          is_rect;
	logic [CW-1:0] x0;
	logic [CW-1:0] y0;
	logic [CW-1:0] ra;
	logic [8:0]    neg_r;
	logic [8:0]    neg_rq;
	logic [7:0]    nrows_d;
	logic [7:0]    ncols_d;
	logic [14:0]   dsum;
	logic          in_shape;
	logic          hit;
	logic          y_ok;
	logic          x_ok;
	logic          row_end;
	logic          last;
	logic          empty;
	logic [16:0]   two_dx1;
	logic [16:0]   two_dy1;

	always_comb begin
		is_disc = (job.cmd == ogp_pkg::CMD_DISC) || (job.cmd == ogp_pkg::CMD_HALF);
		is_rect = (job.cmd == ogp_pkg::CMD_RECT);
		x0      = {{(CW-8){job.pos_x[7]}}, job.pos_x};
		y0      = {{(CW-8){job.pos_y[7]}}, job.pos_y};
		ra      = {{(CW-7){1'b0}}, job.extent_a};
		neg_r   = 9'd0 - {2'b00, job.extent_a};
		if (job.cmd == ogp_pkg::CMD_DISC) begin
			nrows_d = {job.extent_a, 1'b0};
		end else if (is_rect) begin
			nrows_d = {1'b0, job.extent_b};
		end else begin
			nrows_d = {1'b0, job.extent_a};
		end
		ncols_d = is_disc ? {job.extent_a, 1'b0} : {1'b0, job.extent_a};
	end

	assign neg_rq   = 9'd0 - {2'b00, r_q};
	assign dsum     = {1'b0, dx2_q} + {1'b0, dy2_q};
	assign in_shape = disc_q ? (dsum < {1'b0, thr_q}) : (dsum >= {1'b0, thr_q});
	assign hit      = rect_q || in_shape;
	assign y_ok     = !y_q[CW-1] && (y_q < {{(CW-7){1'b0}}, rows_eff});
	assign x_ok     = !x_q[CW-1] && (x_q != '0) && (x_q < {{(CW-7){1'b0}}, cols_eff});
	assign row_end  = (k_q == ncols_q - 8'd1);
	assign last     = row_end && (j_q == nrows_q - 8'd1);
	assign empty    = (nrows_q == 8'd0) || (ncols_q == 8'd0);
	// (d+1)^2 = d^2 + 2d + 1
	assign two_dx1 = {{7{dx_q[8]}}, dx_q, 1'b1};
	assign two_dy1 = {{7{dy_q[8]}}, dy_q, 1'b1};

	assign wr.en  = (state_q == W_RUN) && hit && y_ok && x_ok;
	assign wr.row = y_q;
	assign wr.col = x_q;
	assign done   = ((state_q == W_SQ) && empty) || ((state_q == W_RUN) && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
		end else begin
			case (state_q)
				W_IDLE: begin
					if (start) begin
						state_q <= W_SQ;
					end
				end
				W_SQ: begin
					state_q <= empty ? W_IDLE : W_THR;
				end
				W_THR: begin
					state_q <= W_RUN;
				end
				W_RUN: begin
					if (last) begin
						state_q <= W_IDLE;
					end
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			W_IDLE: begin
				if (start) begin
					disc_q   <= is_disc;
					rect_q   <= is_rect;
					ydn_q    <= is_rect || (job.cmd == ogp_pkg::CMD_BCORNER);
					r_q      <= job.extent_a;
					nrows_q  <= nrows_d;
					ncols_q  <= ncols_d;
					xstart_q <= is_disc ? x0 - ra : x0;
					x_q      <= is_disc ? x0 - ra : x0;
					y_q      <= is_disc ? y0 - ra : y0;
					j_q      <= 8'd0;
					k_q      <= 8'd0;
					dx_q     <= neg_r;
					dy_q     <= neg_r;
				end
			end
			W_SQ: begin
				sq_q <= r_q * r_q;
			end
			W_THR: begin
				// corners test against (r-1)^2 = r^2 - 2r + 1
				thr_q <= disc_q ? sq_q : sq_q - {6'd0, r_q, 1'b0} + 14'd1;
				dx2_q <= sq_q;
				dy2_q <= sq_q;
			end
			W_RUN: begin
				if (row_end) begin
					x_q   <= xstart_q;
					k_q   <= 8'd0;
					dx_q  <= neg_rq;
					dx2_q <= sq_q;
					y_q   <= ydn_q ? y_q - 1'b1 : y_q + 1'b1;
					j_q   <= j_q + 8'd1;
					dy_q  <= dy_q + 9'd1;
					dy2_q <= 14'({3'b000, dy2_q} + two_dy1);
				end else begin
					x_q   <= x_q + 1'b1;
					k_q   <= k_q + 8'd1;
					dx_q  <= dx_q + 9'd1;
					dx2_q <= 14'({3'b000, dx2_q} + two_dx1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[hdl/obstacle_grid_painter.sv]
// Obstacle grid painter. Keeps a MAX_ROWS x MAX_COLS grid of node kinds in one ram
// (row-major, column field padded to a power of two) plus a bodies flag, and takes one
// command word at a time; in_ready stays low while a command is being worked. Init, and
// the clearing pass that runs right after reset, sweep the whole ram one cell per cycle,
// MAX_ROWS * 2^ceil(log2(MAX_COLS)) cells (4096 at the defaults), set by the single ram
// write port. Painting steps through the shape's bounding box one cell per cycle in a
// shared distance unit after setup states that square r and form the threshold (a disc
// of radius r covers 2r x 2r), ending in the first setup state when the box is empty. A
// query reads the ram only inside the grid, else reports an obstacle. Each command
// gives exactly one result word; the next command is taken while a result waits.
// Configuration writes land at once (cfg_ready is high), but only init rebuilds the grid.
// depends on ogp_pkg, ogp_ram, ogp_walker
module obstacle_grid_painter #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [2:0]                         command,
	input  logic signed [7:0]                  pos_x,
	input  logic signed [7:0]                  pos_y,
	input  logic [6:0]                         extent_a,
	input  logic [6:0]                         extent_b,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               cell_is_fluid,
	output logic [2:0]                         cell_kind,
	output logic                               has_bodies,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ogp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ogp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int AW    = RW + CW;
	localparam int DEPTH = MAX_ROWS * (2 ** CW);

	localparam logic [6:0] ROWS_CAP = (MAX_ROWS > 127) ? 7'd127 : 7'(MAX_ROWS);
	localparam logic [6:0] COLS_CAP = (MAX_COLS > 127) ? 7'd127 : 7'(MAX_COLS);
	localparam logic [6:0] ROWS_RST = (ROWS_CAP < 7'd64) ? ROWS_CAP : 7'd64;
	localparam logic [6:0] COLS_RST = (COLS_CAP < 7'd64) ? COLS_CAP : 7'd64;

	localparam logic [2:0] S_SWEEP = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_PAINT = 3'd2;
	localparam logic [2:0] S_QREAD = 3'd3;
	localparam logic [2:0] S_QDATA = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]           state_q;
	logic [6:0]           cfg_rows_q;
	logic [6:0]           cfg_cols_q;
	logic [6:0]           sw_rows_q;
	logic [6:0]           sw_cols_q;
	logic [AW-1:0]        sw_addr_q;
	logic                 sw_rep_q;
	logic                 bodies_q;
	logic [7:0]           qx_q;
	logic [7:0]           qy_q;
	ogp_pkg::kind_t       pend_kind_q;
	logic                 cmd_is_query_q;
	logic                 out_valid_q;
	logic                 res_fluid_q;
	ogp_pkg::kind_t       res_kind_q;
	logic                 res_bodies_q;

	logic [6:0]           rows_eff;
	logic [6:0]           cols_eff;
	logic                 accept;
	logic                 is_paint;
	logic                 q_in;
	logic [10:0]          sy;
	logic [10:0]          sx;
	logic [10:0]          s_rlast;
	logic [10:0]          s_clast;
	logic [10:0]          s_cols;
	ogp_pkg::kind_t       sw_kind;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	ogp_pkg::kind_t       ram_wdata;
	logic [AW-1:0]        ram_raddr;
	ogp_pkg::kind_t       ram_rdata;
	ogp_pkg::ogp_job_t    job;
	ogp_pkg::ogp_wr_t     wr;
	logic                 walk_done;
	logic                 load_out;

	// out of range register values act as the nearest legal size
	assign rows_eff = (cfg_rows_q < 7'd3) ? 7'd3 :
		((cfg_rows_q > ROWS_CAP) ? ROWS_CAP : cfg_rows_q);
	assign cols_eff = (cfg_cols_q < 7'd3) ? 7'd3 :
		((cfg_cols_q > COLS_CAP) ? COLS_CAP : cfg_cols_q);

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign is_paint  = (command == ogp_pkg::CMD_DISC) || (command == ogp_pkg::CMD_HALF) ||
		(command == ogp_pkg::CMD_RECT) || (command == ogp_pkg::CMD_BCORNER) ||
		(command == ogp_pkg::CMD_TCORNER);
	assign q_in = !qy_q[7] && (qy_q[6:0] < rows_eff) && !qx_q[7] && (qx_q[6:0] < cols_eff);

	// frame kind of the cell the sweep is at
	always_comb begin
		sy      = 11'(sw_addr_q[AW-1:CW]);
		sx      = 11'(sw_addr_q[CW-1:0]);
		s_cols  = 11'(sw_cols_q);
		s_rlast = 11'(sw_rows_q) - 11'd1;
		s_clast = s_cols - 11'd1;
		if ((sy == s_rlast) && (sx < s_cols)) begin
			sw_kind = ogp_pkg::KIND_TOP;
		end else if ((sy == 11'd0) && (sx < s_cols)) begin
			sw_kind = ogp_pkg::KIND_BOTTOM;
		end else if ((sy != 11'd0) && (sy < s_rlast) && (sx == 11'd0)) begin
			sw_kind = ogp_pkg::KIND_LEFT;
		end else if ((sy != 11'd0) && (sy < s_rlast) && (sx == s_clast)) begin
			sw_kind = ogp_pkg::KIND_RIGHT;
		end else begin
			sw_kind = ogp_pkg::KIND_FLUID;
		end
	end

	always_comb begin
		if (state_q == S_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = sw_addr_q;
			ram_wdata = sw_kind;
		end else begin
			ram_we    = wr.en;
			ram_waddr = {RW'(wr.row), CW'(wr.col)};
			ram_wdata = ogp_pkg::KIND_OBST;
		end
	end

	assign ram_raddr = {RW'(qy_q[6:0]), CW'(qx_q[6:0])};

	assign job.cmd      = command;
	assign job.pos_x    = pos_x;
	assign job.pos_y    = pos_y;
	assign job.extent_a = extent_a;
	assign job.extent_b = extent_b;

	ogp_ram #(
		.WIDTH(ogp_pkg::KIND_W),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ogp_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && is_paint),
		.job     (job),
		.rows_eff(rows_eff),
		.cols_eff(cols_eff),
		.wr      (wr),
		.done    (walk_done)
	);

	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			cfg_rows_q  <= 7'd64;
			cfg_cols_q  <= 7'd64;
			sw_rows_q   <= ROWS_RST;
			sw_cols_q   <= COLS_RST;
			sw_addr_q   <= '0;
			sw_rep_q    <= 1'b0;
			bodies_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ogp_pkg::REG_ROWS: cfg_rows_q <= cfg_data;
					ogp_pkg::REG_COLS: cfg_cols_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_SWEEP: begin
					sw_addr_q <= sw_addr_q + 1'b1;
					if (sw_addr_q == AW'(DEPTH - 1)) begin
						state_q <= sw_rep_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (command == ogp_pkg::CMD_INIT) begin
							sw_rows_q <= rows_eff;
							sw_cols_q <= cols_eff;
							sw_addr_q <= '0;
							sw_rep_q  <= 1'b1;
							bodies_q  <= 1'b0;
							state_q   <= S_SWEEP;
						end else if (is_paint) begin
							bodies_q <= 1'b1;
							state_q  <= S_PAINT;
						end else if (command == ogp_pkg::CMD_QUERY) begin
							state_q <= S_QREAD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_PAINT: begin
					if (walk_done) begin
						state_q <= S_DONE;
					end
				end
				S_QREAD: begin
					state_q <= q_in ? S_QDATA : S_DONE;
				end
				S_QDATA: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q        <= pos_x;
			qy_q        <= pos_y;
			pend_kind_q <= ogp_pkg::KIND_FLUID;
		end
		if ((state_q == S_QREAD) && !q_in) begin
			pend_kind_q <= ogp_pkg::KIND_OBST;
		end
		if (state_q == S_QDATA) begin
			pend_kind_q <= ram_rdata;
		end
		if (load_out) begin
			res_kind_q   <= pend_kind_q;
			res_fluid_q  <= (cmd_is_query_q) && (pend_kind_q == ogp_pkg::KIND_FLUID);
			res_bodies_q <= bodies_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_is_query_q <= (command == ogp_pkg::CMD_QUERY);
		end
	end

	assign out_valid     = out_valid_q;
	assign cell_is_fluid = res_fluid_q;
	assign cell_kind     = res_kind_q;
	assign has_bodies    = res_bodies_q;

endmodule
